>>> hw/rtl/dfs_pkg.sv
// ----------------------------------------------------------------------------
// dfs_pkg
// Shared types, character codes and helpers of the delimited field splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package dfs_pkg;

    // character codes
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_DQ  = 8'h22;
    localparam logic [7:0] CH_SQ  = 8'h27;
    localparam logic [7:0] CH_BS  = 8'h5C;
    localparam logic [7:0] CH_LN  = 8'h6E;  // 'n'
    localparam logic [7:0] CH_LR  = 8'h72;  // 'r'
    localparam logic [7:0] CH_LT  = 8'h74;  // 't'

    localparam logic [7:0] DELIM_RESET = 8'd44;

    // open quote kind
    typedef logic [1:0] t_quote;
    localparam t_quote Q_NONE   = 2'd0;
    localparam t_quote Q_SINGLE = 2'd1;
    localparam t_quote Q_DOUBLE = 2'd2;

    // store read address select
    typedef logic [1:0] t_rd_sel;
    localparam t_rd_sel RD_S  = 2'd0;
    localparam t_rd_sel RD_E  = 2'd1;
    localparam t_rd_sel RD_I  = 2'd2;
    localparam t_rd_sel RD_I1 = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic    accept;       // input transfer this cycle
        logic    load;         // field ended: capture bounds and flags
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    latch_first;  // keep store[s]
        logic    step_s;
        logic    step_e;
        logic    trim_done;    // strip outer quotes, set i
        logic    push_plain;
        logic    push_esc;
        logic    push_empty;
    } t_dfs_cmd;

    // datapath -> controller
    typedef struct packed {
        logic emit_req;   // current input byte ends a field with output
        logic len_zero;
        logic s_trim;     // s < e and store[s] is whitespace
        logic e_trim;     // s < e and store[e] is whitespace
        logic i_gt_e;
        logic bs_pair;    // backslash with a following byte in range
        logic last_plain;
        logic last_esc;
        logic out_free;
    } t_dfs_sts;

    typedef struct packed {
        logic [7:0] ch;
        logic       take;  // consumes the following byte
    } t_unesc;

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c >= CH_TAB && c <= CH_CR) || c == CH_SP;
    endfunction

    function automatic t_unesc unescape(input logic [7:0] nx, input logic [7:0] delim);
        t_unesc u;
        u.take = 1'b1;
        if (nx == CH_LN)       u.ch = CH_NL;
        else if (nx == CH_LR)  u.ch = CH_CR;
        else if (nx == CH_LT)  u.ch = CH_TAB;
        else if (nx == CH_DQ)  u.ch = CH_DQ;
        else if (nx == CH_SQ)  u.ch = CH_SQ;
        else if (nx == CH_BS)  u.ch = CH_BS;
        else if (nx == delim)  u.ch = delim;
        else begin
            u.ch   = CH_BS;
            u.take = 1'b0;
        end
        unescape = u;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dfs_ram.sv
// ----------------------------------------------------------------------------
// dfs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/dfs_ctrl.sv
// ----------------------------------------------------------------------------
// dfs_ctrl
// Sequencer: byte intake, edge trimming, quote strip and unescape walk.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire dfs_pkg::t_dfs_sts i_sts,
    output dfs_pkg::t_dfs_cmd      o_cmd
);
    import dfs_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SRD   = 3'd1;
    localparam logic [2:0] ST_SCK   = 3'd2;
    localparam logic [2:0] ST_ERD   = 3'd3;
    localparam logic [2:0] ST_ECK   = 3'd4;
    localparam logic [2:0] ST_URD   = 3'd5;
    localparam logic [2:0] ST_UC    = 3'd6;
    localparam logic [2:0] ST_UN    = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_empty;   // pending empty result
    logic       n_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_empty <= 1'b0;
        end else begin
            r_state <= n_state;
            r_empty <= n_empty;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE) || r_empty;

    always_comb begin
        n_state = r_state;
        n_empty = r_empty;
        o_cmd   = '0;
        o_cmd.rd_sel = RD_S;
        unique case (r_state)
            ST_IDLE: begin
                if (r_empty) begin
                    if (i_sts.out_free) begin
                        o_cmd.push_empty = 1'b1;
                        n_empty          = 1'b0;
                    end
                end else if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.emit_req) begin
                        o_cmd.load = 1'b1;
                        if (i_sts.len_zero) n_empty = 1'b1;
                        else                n_state = ST_SRD;
                    end
                end
            end
            ST_SRD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_S;
                n_state      = ST_SCK;
            end
            ST_SCK: begin
                o_cmd.latch_first = 1'b1;
                if (i_sts.s_trim) begin
                    o_cmd.step_s = 1'b1;
                    n_state      = ST_SRD;
                end else begin
                    n_state = ST_ERD;
                end
            end
            ST_ERD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_E;
                n_state      = ST_ECK;
            end
            ST_ECK: begin
                if (i_sts.e_trim) begin
                    o_cmd.step_e = 1'b1;
                    n_state      = ST_ERD;
                end else begin
                    o_cmd.trim_done = 1'b1;
                    n_state         = ST_URD;
                end
            end
            ST_URD: begin
                if (i_sts.i_gt_e) begin
                    // quotes only: nothing left after stripping
                    n_empty = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_I;
                    n_state      = ST_UC;
                end
            end
            ST_UC: begin
                if (i_sts.bs_pair) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_I1;
                    n_state      = ST_UN;
                end else if (i_sts.out_free) begin
                    o_cmd.push_plain = 1'b1;
                    n_state          = i_sts.last_plain ? ST_IDLE : ST_URD;
                end
            end
            ST_UN: begin
                if (i_sts.out_free) begin
                    o_cmd.push_esc = 1'b1;
                    n_state        = i_sts.last_esc ? ST_IDLE : ST_URD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/dfs_datapath.sv
// ----------------------------------------------------------------------------
// dfs_datapath
// Field state, bounds, unescape and output register of the splitter.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_datapath #(
    parameter int FIELD_MAX = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire dfs_pkg::t_dfs_cmd            i_cmd,
    output dfs_pkg::t_dfs_sts                 o_sts,
    input  wire logic                         i_cfg_we,
    input  wire logic [7:0]                   i_cfg_data,
    input  wire logic [7:0]                   i_in_byte,
    output logic                              o_wr_en,
    output logic [$clog2(FIELD_MAX)-1:0]      o_wr_addr,
    output logic                              o_rd_en,
    output logic [$clog2(FIELD_MAX)-1:0]      o_rd_addr,
    input  wire logic [7:0]                   i_rd_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [7:0]                        o_out_byte,
    output logic                              o_end_of_field,
    output logic                              o_end_of_line,
    output logic                              o_empty_field,
    output logic                              o_truncated
);
    import dfs_pkg::*;

    localparam int AW = $clog2(FIELD_MAX);
    localparam int LW = $clog2(FIELD_MAX + 1);
    localparam int IW = $clog2(FIELD_MAX + 2);

    // field intake state
    logic [7:0]    r_delim;
    logic [LW-1:0] r_len,   n_len;
    t_quote        r_quote, n_quote;
    logic          r_esc,   n_esc;
    logic          r_ovf,   n_ovf;
    logic          r_aft_nl, n_aft_nl;
    // emit bounds
    logic [AW-1:0] r_s, n_s;
    logic [AW-1:0] r_e, n_e;
    logic [IW-1:0] r_i, n_i;
    logic [7:0]    r_first;
    logic          r_eol, r_tr;

    logic    is_nl, is_q, nul_skip, line_end, delim_hit, put, strip;
    t_quote  q_kind;
    t_unesc  ue;
    logic [IW-1:0] e_ext, i_inc1, i_inc_esc;

    assign is_nl     = (i_in_byte == CH_NL);
    assign is_q      = (i_in_byte == CH_DQ) || (i_in_byte == CH_SQ);
    assign q_kind    = (i_in_byte == CH_SQ) ? Q_SINGLE : Q_DOUBLE;
    assign nul_skip  = (i_in_byte == CH_NUL) && r_aft_nl;
    assign line_end  = (i_in_byte == CH_NUL) || (is_nl && !r_esc);
    assign delim_hit = (i_in_byte != CH_CR) && (r_quote == Q_NONE) && (i_in_byte == r_delim)
                       && !r_esc && (i_in_byte != CH_BS) && !is_q;
    assign put       = !nul_skip && !line_end && !delim_hit;

    assign o_sts.emit_req = !nul_skip && ((line_end && r_quote == Q_NONE) ||
                                          (!line_end && delim_hit));
    assign o_sts.len_zero = (r_len == '0);

    // raw byte write
    assign o_wr_en   = i_cmd.accept && put && (r_len < LW'(FIELD_MAX));
    assign o_wr_addr = AW'(r_len);

    // bounds status
    assign e_ext     = IW'(r_e);
    assign i_inc1    = r_i + IW'(1);
    assign ue        = unescape(i_rd_data, r_delim);
    assign i_inc_esc = r_i + (ue.take ? IW'(2) : IW'(1));
    assign strip     = (r_s != r_e) && (r_first == CH_DQ || r_first == CH_SQ)
                       && (r_first == i_rd_data);

    assign o_sts.s_trim     = (r_s < r_e) && is_ws(i_rd_data);
    assign o_sts.e_trim     = (r_s < r_e) && is_ws(i_rd_data);
    assign o_sts.i_gt_e     = (r_i > e_ext);
    assign o_sts.bs_pair    = (i_rd_data == CH_BS) && (i_inc1 <= e_ext);
    assign o_sts.last_plain = (i_inc1 > e_ext);
    assign o_sts.last_esc   = (i_inc_esc > e_ext);
    assign o_sts.out_free   = !o_out_valid || !i_out_stall;

    assign o_rd_en = i_cmd.rd_en;
    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_S:    o_rd_addr = r_s;
            RD_E:    o_rd_addr = r_e;
            RD_I:    o_rd_addr = AW'(r_i);
            RD_I1:   o_rd_addr = AW'(i_inc1);
            default: o_rd_addr = r_s;
        endcase
    end

    always_comb begin
        n_len    = r_len;
        n_quote  = r_quote;
        n_esc    = r_esc;
        n_ovf    = r_ovf;
        n_aft_nl = r_aft_nl;
        n_s      = r_s;
        n_e      = r_e;
        n_i      = r_i;
        if (i_cmd.accept) begin
            if (nul_skip) begin
                n_aft_nl = 1'b0;
            end else begin
                n_aft_nl = line_end && is_nl;
                if (put) begin
                    if (r_len < LW'(FIELD_MAX)) n_len = r_len + LW'(1);
                    else                        n_ovf = 1'b1;
                    if (r_esc) begin
                        n_esc = 1'b0;
                    end else if (i_in_byte == CH_BS) begin
                        n_esc = 1'b1;
                    end else if (is_q) begin
                        n_quote = (r_quote == q_kind) ? Q_NONE : q_kind;
                    end
                end else begin
                    // field ended (emitted, or dropped inside a quote)
                    n_len   = '0;
                    n_quote = Q_NONE;
                    n_esc   = 1'b0;
                    n_ovf   = 1'b0;
                end
            end
        end
        if (i_cmd.load) begin
            n_s = '0;
            n_e = AW'(r_len - LW'(1));
        end
        if (i_cmd.step_s) n_s = r_s + AW'(1);
        if (i_cmd.step_e) n_e = r_e - AW'(1);
        if (i_cmd.trim_done) begin
            if (strip) begin
                n_i = IW'(r_s) + IW'(1);
                n_e = r_e - AW'(1);
            end else begin
                n_i = IW'(r_s);
            end
        end
        if (i_cmd.push_plain) n_i = i_inc1;
        if (i_cmd.push_esc)   n_i = i_inc_esc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim  <= DELIM_RESET;
            r_len    <= '0;
            r_quote  <= Q_NONE;
            r_esc    <= 1'b0;
            r_ovf    <= 1'b0;
            r_aft_nl <= 1'b0;
        end else begin
            if (i_cfg_we) r_delim <= i_cfg_data;
            r_len    <= n_len;
            r_quote  <= n_quote;
            r_esc    <= n_esc;
            r_ovf    <= n_ovf;
            r_aft_nl <= n_aft_nl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s;
        r_e <= n_e;
        r_i <= n_i;
        if (i_cmd.latch_first) r_first <= i_rd_data;
        if (i_cmd.load) begin
            r_eol <= line_end;
            r_tr  <= r_ovf;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.push_plain || i_cmd.push_esc || i_cmd.push_empty) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_plain || i_cmd.push_esc || i_cmd.push_empty) begin
            o_end_of_line <= r_eol;
            o_truncated   <= r_tr;
            o_empty_field <= i_cmd.push_empty;
        end
        if (i_cmd.push_plain) begin
            o_out_byte     <= i_rd_data;
            o_end_of_field <= o_sts.last_plain;
        end else if (i_cmd.push_esc) begin
            o_out_byte     <= ue.ch;
            o_end_of_field <= o_sts.last_esc;
        end else if (i_cmd.push_empty) begin
            o_out_byte     <= 8'd0;
            o_end_of_field <= 1'b1;
        end
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(FIELD_MAX))
        else $error("field length beyond store depth");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_len == LW'(FIELD_MAX)))
        else $error("overflow flagged with room left");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push_plain || i_cmd.push_esc || i_cmd.push_empty) |-> o_sts.out_free)
        else $error("result pushed into occupied output register");

    a_push_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.push_plain, i_cmd.push_esc, i_cmd.push_empty}))
        else $error("more than one result source");

endmodule

`default_nettype wire

>>> hw/rtl/delimited_field_splitter_top.sv
// ----------------------------------------------------------------------------
// delimited_field_splitter_top
// Splits a byte stream into delimited fields and sends each field trimmed,
// quote-stripped and unescaped, one byte per result transfer.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-------------------------
//  in       | into      | i_in_valid / o_in_stall   | i_in_byte
//  out      | out of    | o_out_valid / i_out_stall | o_out_byte, o_end_of_field,
//           |           |                           | o_end_of_line, o_empty_field,
//           |           |                           | o_truncated
//  cfg      | into      | i_cfg_we                  | i_cfg_data (delimiter)
//
//  A byte that does not end a field starts no walk.
//  A field end with stored bytes starts the emit walk over the field store RAM,
//  one registered read at a time on its single read port: read and check
//  each edge, again per trimmed edge byte, then read and push each plain
//  result, and read twice and push for each escape pair. An empty result is
//  pushed from idle after the field end or after a walk that leaves nothing.
//  Reset (i_rst_n low, synchronous) clears the field intake state and sets the
//  delimiter to 44; the emit bounds and the store itself are not cleared.
//  Intake stays stalled during the walk; a stalled output only holds it there.
//  The last result may still wait in the output register while bytes flow in.
// ----------------------------------------------------------------------------
`default_nettype none

module delimited_field_splitter_top #(
    parameter int FIELD_MAX = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // configuration
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_data,
    // input channel
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_in_byte,
    // output channel
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_end_of_field,
    output logic            o_end_of_line,
    output logic            o_empty_field,
    output logic            o_truncated
);
    import dfs_pkg::*;

    localparam int AW = $clog2(FIELD_MAX);

    t_dfs_cmd      cmd;
    t_dfs_sts      sts;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    rd_data;

    // sequencer
    dfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // field state, bounds and output register
    dfs_datapath #(
        .FIELD_MAX (FIELD_MAX)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_byte      (i_in_byte),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_end_of_field (o_end_of_field),
        .o_end_of_line  (o_end_of_line),
        .o_empty_field  (o_empty_field),
        .o_truncated    (o_truncated)
    );

    // raw field store
    dfs_ram #(
        .WIDTH (8),
        .DEPTH (FIELD_MAX)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

`default_nettype wire

>>> sim/dfs_field_checker.sv
// ----------------------------------------------------------------------------
// dfs_field_checker
// Watches the splitter's ports, predicts the sanitised fields from each
// accepted byte and compares every result transfer against the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_field_checker #(
    parameter int FIELD_MAX = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_stall,
    input  wire logic [7:0] i_out_byte,
    input  wire logic       i_end_of_field,
    input  wire logic       i_end_of_line,
    input  wire logic       i_empty_field,
    input  wire logic       i_truncated,
    output int              o_mismatches,
    output int              o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import dfs_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       eof;
        logic       eol;
        logic       empty;
        logic       trunc;
    } t_field_result;

    t_field_result awaited_q[$];

    // shadow of the splitter state
    logic [7:0] raw_bytes [FIELD_MAX];
    int         raw_len;
    t_quote     quote_open;
    bit         escaped;
    bit         overflowed;
    bit         after_nl;
    logic [7:0] delim;

    int mismatch_cnt = 0;
    int outstanding_cnt = 0;

    assign o_mismatches  = mismatch_cnt;
    assign o_outstanding = outstanding_cnt;

    function automatic bit is_blank(input logic [7:0] c);
        return (c >= CH_TAB && c <= CH_CR) || c == CH_SP;
    endfunction

    function automatic void clear_field();
        raw_len    = 0;
        quote_open = Q_NONE;
        escaped    = 1'b0;
        overflowed = 1'b0;
    endfunction

    function automatic void store_raw(input logic [7:0] b);
        if (raw_len < FIELD_MAX) begin
            raw_bytes[raw_len] = b;
            raw_len++;
        end else begin
            overflowed = 1'b1;
        end
    endfunction

    // trim, strip the outer quote pair, unescape, queue the results
    function automatic void flush_field(input bit eol);
        logic [7:0]    clean [FIELD_MAX];
        logic [7:0]    nx;
        logic [7:0]    ch;
        t_field_result r;
        int            n_clean;
        int            step;
        int            lo;
        int            hi;
        int            i;
        n_clean = 0;
        lo = 0;
        hi = raw_len - 1;
        if (raw_len > 0) begin
            while (lo < hi && is_blank(raw_bytes[lo])) lo++;
            while (lo < hi && is_blank(raw_bytes[hi])) hi--;
            if (lo != hi && (raw_bytes[lo] == CH_DQ || raw_bytes[lo] == CH_SQ) &&
                raw_bytes[lo] == raw_bytes[hi]) begin
                lo++;
                hi--;
            end
            i = lo;
            while (i <= hi) begin
                ch   = raw_bytes[i];
                step = 1;
                if (raw_bytes[i] == CH_BS && i < hi) begin
                    nx   = raw_bytes[i + 1];
                    step = 2;
                    case (nx)
                        CH_LN:               ch = CH_NL;
                        CH_LR:               ch = CH_CR;
                        CH_LT:               ch = CH_TAB;
                        CH_DQ, CH_SQ, CH_BS: ch = nx;
                        default: begin
                            if (nx == delim) begin
                                ch = delim;
                            end else begin
                                ch   = CH_BS;
                                step = 1;
                            end
                        end
                    endcase
                end
                clean[n_clean] = ch;
                n_clean++;
                i += step;
            end
        end
        r.eol   = eol;
        r.trunc = overflowed;
        if (n_clean == 0) begin
            r.ch    = '0;
            r.eof   = 1'b1;
            r.empty = 1'b1;
            awaited_q.insert(awaited_q.size(), r);
        end else begin
            r.empty = 1'b0;
            for (int k = 0; k < n_clean; k++) begin
                r.ch  = clean[k];
                r.eof = (k == n_clean - 1);
                awaited_q.insert(awaited_q.size(), r);
            end
        end
        clear_field();
    endfunction

    function automatic void take_byte(input logic [7:0] b);
        t_quote q;
        if (b == CH_NUL && after_nl) begin
            after_nl = 1'b0;
        end else if (b == CH_NUL || (b == CH_NL && !escaped)) begin
            // line end; inside a quote the field is thrown away
            if (quote_open != Q_NONE) clear_field();
            else flush_field(1'b1);
            after_nl = (b == CH_NL);
        end else begin
            after_nl = 1'b0;
            if (escaped) begin
                store_raw(b);
                escaped = 1'b0;
            end else if (b == CH_BS) begin
                store_raw(b);
                escaped = 1'b1;
            end else if (b == CH_DQ || b == CH_SQ) begin
                q = (b == CH_SQ) ? Q_SINGLE : Q_DOUBLE;
                store_raw(b);
                quote_open = (quote_open == q) ? Q_NONE : q;
            end else if (b != CH_CR && quote_open == Q_NONE && b == delim) begin
                flush_field(1'b0);
            end else begin
                store_raw(b);
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
            mismatch_cnt++;
        end
    endfunction

    function automatic void check_result();
        t_field_result want;
        if (awaited_q.size() == 0) begin
            $error("out_byte: expected no result, got 0x%02h", i_out_byte);
            mismatch_cnt++;
        end else begin
            want = awaited_q.pop_front();
            check_field("out_byte",     want.ch,              i_out_byte);
            check_field("end_of_field", 8'(want.eof),   8'(i_end_of_field));
            check_field("end_of_line",  8'(want.eol),   8'(i_end_of_line));
            check_field("empty_field",  8'(want.empty), 8'(i_empty_field));
            check_field("truncated",    8'(want.trunc), 8'(i_truncated));
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_field();
            after_nl = 1'b0;
            delim    = DELIM_RESET;
            awaited_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_result();
            // a byte taken at this edge still sees the old delimiter
            if (i_in_valid && !i_in_stall) take_byte(i_in_byte);
            if (i_cfg_we) delim = i_cfg_data;
        end
        outstanding_cnt = awaited_q.size();
    end

endmodule

`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives text bytes into the delimited field splitter under a series of
// delimiter settings, with random gaps and stalls on both channels; the
// checker beside the block predicts and compares every result transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dfs_pkg::*;

    localparam int FIELD_MAX    = 64;
    localparam int N_PHASES     = 8;    // one delimiter setting per phase
    localparam int PHASE_ITEMS  = 1;    // at least one generated line per phase
    localparam int SETTLE       = 8;    // idle cycles before a delimiter write
    localparam int TAIL_CYCLES  = 40;
    localparam int HOLD_AT      = 30;   // result index where the long hold starts
    localparam int LONG_HOLD    = 300;
    // ~250 bytes of stimulus; the watchdog ends the run once this limit is reached.
    localparam int CYCLE_LIMIT  = 1000000;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       cfg_we   = 1'b0;
    logic [7:0] cfg_data = 8'h00;
    logic       in_valid = 1'b0;
    logic [7:0] in_byte  = 8'h00;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       end_of_field;
    logic       end_of_line;
    logic       empty_field;
    logic       truncated;
    int         mismatches;
    int         outstanding;

    // generator state
    logic [7:0] line_q[$];
    logic [7:0] cur_delim  = DELIM_RESET;
    logic [7:0] last_sent  = 8'h00;
    int         n_items    = 0;
    bit         send_quiet = 1'b0;
    bit         take_quiet = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    delimited_field_splitter_top #(
        .FIELD_MAX (FIELD_MAX)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_in_byte      (in_byte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_out_byte     (out_byte),
        .o_end_of_field (end_of_field),
        .o_end_of_line  (end_of_line),
        .o_empty_field  (empty_field),
        .o_truncated    (truncated)
    );

    dfs_field_checker #(
        .FIELD_MAX (FIELD_MAX)
    ) i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_byte      (in_byte),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_byte     (out_byte),
        .i_end_of_field (end_of_field),
        .i_end_of_line  (end_of_line),
        .i_empty_field  (empty_field),
        .i_truncated    (truncated),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    // ------------------------------------------------------------------------
    // Byte generators. They only fill line_q; send_line pushes it out.
    // ------------------------------------------------------------------------

    function automatic void add_byte(input logic [7:0] b);
        line_q.insert(line_q.size(), b);
    endfunction

    // letters and digits; 'n', 'r' and 't' turn up and pair with backslashes
    function automatic logic [7:0] pick_letter();
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(8'h30, 8'h39));
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    function automatic void add_token(input bit quoted);
        int r;
        r = $urandom_range(0, 19);
        if (r < 10 || r > 17) begin
            add_byte(pick_letter());
        end else if (r < 12) begin
            add_byte((r == 10) ? CH_SP : CH_TAB);
        end else if (r < 15) begin
            // escape pair: every known escape, the delimiter, or an unknown byte
            add_byte(CH_BS);
            case ($urandom_range(0, 7))
                0: add_byte(CH_LN);
                1: add_byte(CH_LR);
                2: add_byte(CH_LT);
                3: add_byte(CH_DQ);
                4: add_byte(CH_SQ);
                5: add_byte(CH_BS);
                6: add_byte(cur_delim);
                default: add_byte(pick_letter());
            endcase
        end else if (r == 15) begin
            // a delimiter only stays data inside a quote
            add_byte(quoted ? cur_delim : pick_letter());
        end else if (r == 16) begin
            add_byte(CH_CR);
        end else begin
            add_byte(8'($urandom_range(8'h80, 8'hFF)));
        end
    endfunction

    // optional blanks, optional matching quote pair, a few tokens
    function automatic void add_field();
        int kind;
        kind = $urandom_range(0, 4);
        repeat ($urandom_range(0, 2)) add_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
        if (kind == 3) add_byte(CH_SQ);
        if (kind == 4) add_byte(CH_DQ);
        repeat ($urandom_range(0, 4)) add_token(kind >= 3);
        if (kind == 3) add_byte(CH_SQ);
        if (kind == 4) add_byte(CH_DQ);
        repeat ($urandom_range(0, 2)) add_byte($urandom_range(0, 1) ? CH_SP : CH_CR);
    endfunction

    function automatic void add_line();
        int n_fields;
        n_fields = $urandom_range(1, 3);
        for (int k = 0; k < n_fields; k++) begin
            add_field();
            if (k + 1 < n_fields) add_byte(cur_delim);
        end
        case ($urandom_range(0, 5))
            0: add_byte(CH_NUL);
            1: begin
                // NUL straight after a newline is swallowed
                add_byte(CH_NL);
                add_byte(CH_NUL);
            end
            default: add_byte(CH_NL);
        endcase
    endfunction

    function automatic void add_noise();
        case ($urandom_range(0, 2))
            0: repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
            1: begin
                // quote never closed: the line end drops the field
                add_byte($urandom_range(0, 1) ? CH_SQ : CH_DQ);
                repeat ($urandom_range(0, 4)) add_token(1'b1);
                add_byte(CH_NL);
            end
            default: begin
                // double opens, single takes over and closes: no outer pair
                add_byte(CH_DQ);
                repeat ($urandom_range(0, 3)) add_byte(pick_letter());
                add_byte(CH_SQ);
                repeat ($urandom_range(0, 3)) add_byte(pick_letter());
                add_byte(CH_SQ);
                add_byte(CH_NL);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Input channel. Each transfer is preceded by a random gap, except in
    // quiet stretches; valid stays up until the byte is taken, and between
    // back-to-back bytes it is never dropped.
    // ------------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (n_items % 16 == 0) send_quiet = ($urandom_range(0, 3) == 0);
        gap = send_quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_byte  <= b;
        do @(posedge clk); while (in_stall);
        // a swallowed NUL is not counted as stimulus
        if (!(b == CH_NUL && last_sent == CH_NL)) n_items++;
        last_sent = b;
    endtask

    task automatic send_line();
        foreach (line_q[k]) push_byte(line_q[k]);
        line_q.delete();
    endtask

    // let every predicted result drain, then settle with valid low, so that the
    // block is idle for a register write
    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Output channel: random stalls per result, quiet stretches, and one
    // long hold while the sender keeps offering, so the block backs up.
    // ------------------------------------------------------------------------
    initial begin
        int hold;
        int n_taken;
        n_taken = 0;
        wait (rst_n === 1'b1);
        forever begin
            if (n_taken % 16 == 0) take_quiet = ($urandom_range(0, 3) == 0);
            if (n_taken == HOLD_AT) hold = LONG_HOLD;
            else hold = take_quiet ? 0 : $urandom_range(0, 9);
            if (hold > 0) begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (hold - 1) @(negedge clk);
                @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            n_taken++;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int phase_end;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Opening bytes at the reset delimiter:
        //  blank-padded quoted field with an escaped double quote;
        //  single quote switched to double, then a line end inside it (dropped);
        //  NUL after that newline (swallowed);
        //  blanks only (the last one survives trimming);
        //  lone trailing backslash ended by NUL;
        //  empty field;
        //  byte 0xFF, backslash before a newline (kept), unknown escape.
        line_q = '{CH_SP, CH_DQ, 8'h61, CH_BS, CH_DQ, 8'h62, CH_DQ, CH_SP, DELIM_RESET,
                   CH_SQ, 8'h78, CH_DQ, CH_NL,
                   CH_NUL,
                   CH_TAB, CH_CR, DELIM_RESET,
                   CH_BS, CH_NUL,
                   DELIM_RESET,
                   8'hFF, CH_BS, CH_NL, CH_BS, 8'h71, CH_NL};
        send_line();

        for (int p = 0; p < N_PHASES; p++) begin
            if (p > 0) begin
                case (p)
                    1:  cur_delim = CH_NUL;    // delimiter acts as a line end
                    2:  cur_delim = CH_DQ;     // quote never delimits
                    3:  cur_delim = CH_BS;
                    4:  cur_delim = CH_CR;
                    5:  cur_delim = CH_NL;
                    6:  cur_delim = CH_LN;     // clashes with the \n escape
                    default: cur_delim = 8'($urandom_range(0, 255));
                endcase
                quiesce();
                cfg_data <= cur_delim;
                cfg_we   <= 1'b1;
                @(negedge clk);
                cfg_we   <= 1'b0;
            end

            // raw field of exactly the store size, then one that overflows it
            if (p < 2) begin
                repeat ((p == 0) ? FIELD_MAX : $urandom_range(FIELD_MAX + 1, FIELD_MAX + 8))
                    add_byte(($urandom_range(0, 9) == 0) ? CH_SP : pick_letter());
                add_byte(cur_delim);
                add_byte(CH_NL);
                send_line();
            end

            phase_end = n_items + PHASE_ITEMS;
            while (n_items < phase_end) begin
                if ($urandom_range(0, 4) == 0) add_noise();
                else add_line();
                send_line();
            end
        end

        quiesce();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("** delimited_field_splitter_top: PASSED **");
        end else begin
            $display("** delimited_field_splitter_top: FAILED **");
        end
        $finish;
    end

    // watchdog
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("** delimited_field_splitter_top: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
